### rtl/base64url_codec_core_assert.svh
// ----------------------------------------------------------------------------
// base64url codec assertion macros
// Concurrent assertion helpers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BASE64URL_CODEC_CORE_ASSERT_SVH
`define BASE64URL_CODEC_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define B64U_ASSERT(lbl, clock, reset_n, prop) \
    lbl: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
        else $error("b64u assertion failed");
// condition must never be true outside reset
`define B64U_ASSERT_NEVER(lbl, clock, reset_n, cond) \
    lbl: assert property (@(posedge clock) disable iff (!reset_n) !(cond)) \
        else $error("b64u forbidden condition seen");
`else
`define B64U_ASSERT(lbl, clock, reset_n, prop)
`define B64U_ASSERT_NEVER(lbl, clock, reset_n, cond)
`endif

`endif

### rtl/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types and alphabet helpers for the base64url codec.
// ----------------------------------------------------------------------------
package b64u_pkg;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       bad_char;
        logic       end_of_message;
    } out_item_t;

    // kind of work handed from front to back
    typedef enum logic [1:0] {
        KIND_ENC = 2'd0,
        KIND_DEC = 2'd1,
        KIND_BAD = 2'd2,
        KIND_END = 2'd3
    } work_kind_t;

    // one queued job: up to four results taken from a 24-bit group
    typedef struct packed {
        work_kind_t  kind;
        logic [23:0] value;
        logic [1:0]  last_idx;
        logic        eom;
    } work_t;

    // decoded character
    typedef struct packed {
        logic       bad;
        logic [5:0] value;
    } sextet_t;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_DASH    = 8'h2d;
    localparam logic [7:0] CHAR_USCORE  = 8'h5f;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sextet_to_char(logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = CHAR_UPPER_A + {2'b00, v};
        else if (v < 6'd52)
            c = CHAR_LOWER_A + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = CHAR_DASH;
        else
            c = CHAR_USCORE;
        return c;
    endfunction

    // alphabet character to 6-bit value, bad flag for anything else
    function automatic sextet_t char_to_sextet(logic [7:0] c);
        sextet_t r;
        r.bad   = 1'b0;
        r.value = 6'd0;
        case (c) inside
            [CHAR_UPPER_A:CHAR_UPPER_Z]: r.value = 6'(c - CHAR_UPPER_A);
            [CHAR_LOWER_A:CHAR_LOWER_Z]: r.value = 6'(c - CHAR_LOWER_A + 8'd26);
            [CHAR_DIGIT_0:CHAR_DIGIT_9]: r.value = 6'(c - CHAR_DIGIT_0 + 8'd52);
            CHAR_DASH:                   r.value = 6'd62;
            CHAR_USCORE:                 r.value = 6'd63;
            default:                     r.bad   = 1'b1;
        endcase
        return r;
    endfunction

endpackage

### rtl/b64u_front.sv
// ----------------------------------------------------------------------------
// b64u_front
// Takes input transfers, tracks group state and queues one job per group or bad character.
// ----------------------------------------------------------------------------
module b64u_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                accept,
    input  b64u_pkg::in_item_t  in_data,
    output logic                work_push,
    output b64u_pkg::work_t     work_data
);

    logic        mode_reg,    mode_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [17:0] held_reg,    held_next;
    logic        discard_reg, discard_next;

    logic             last;
    logic [7:0]       b;
    b64u_pkg::sextet_t s;

    assign b    = in_data.data_byte;
    assign last = in_data.last_in;
    assign s    = b64u_pkg::char_to_sextet(b);

    // group bookkeeping and job building
    always_comb
    begin
        mode_next          = mode_reg;
        phase_next         = phase_reg;
        held_next          = held_reg;
        discard_next       = discard_reg;
        work_push          = 1'b0;
        work_data.kind     = b64u_pkg::KIND_ENC;
        work_data.value    = 24'd0;
        work_data.last_idx = 2'd0;
        work_data.eom      = last;

        if (cfg_wr_en)
        begin
            mode_next    = cfg_wr_data;
            phase_next   = 2'd0;
            held_next    = 18'd0;
            discard_next = 1'b0;
        end
        else if (accept)
        begin
            if (discard_reg)
            begin
                // drop rest of a bad message
                if (last)
                    discard_next = 1'b0;
            end
            else if (mode_reg)
            begin
                // encode: three bytes per group
                work_data.kind = b64u_pkg::KIND_ENC;
                case (phase_reg)
                    2'd0:
                    begin
                        held_next  = {10'd0, b};
                        phase_next = 2'd1;
                        if (last)
                        begin
                            work_push          = 1'b1;
                            work_data.value    = {b, 16'd0};
                            work_data.last_idx = 2'd1;
                        end
                    end
                    2'd1:
                    begin
                        held_next  = {2'd0, held_reg[7:0], b};
                        phase_next = 2'd2;
                        if (last)
                        begin
                            work_push          = 1'b1;
                            work_data.value    = {held_reg[7:0], b, 8'd0};
                            work_data.last_idx = 2'd2;
                        end
                    end
                    default:
                    begin
                        work_push          = 1'b1;
                        work_data.value    = {held_reg[15:0], b};
                        work_data.last_idx = 2'd3;
                    end
                endcase
                if (work_push)
                begin
                    phase_next = 2'd0;
                    held_next  = 18'd0;
                end
            end
            else if (s.bad)
            begin
                // decode: character outside the alphabet
                work_push          = 1'b1;
                work_data.kind     = b64u_pkg::KIND_BAD;
                work_data.eom      = 1'b1;
                phase_next         = 2'd0;
                held_next          = 18'd0;
                discard_next       = !last;
            end
            else
            begin
                // decode: four characters per group
                work_data.kind = b64u_pkg::KIND_DEC;
                case (phase_reg)
                    2'd0:
                    begin
                        held_next  = {12'd0, s.value};
                        phase_next = 2'd1;
                        if (last)
                        begin
                            work_push      = 1'b1;
                            work_data.kind = b64u_pkg::KIND_END;
                        end
                    end
                    2'd1:
                    begin
                        held_next  = {6'd0, held_reg[5:0], s.value};
                        phase_next = 2'd2;
                        if (last)
                        begin
                            work_push          = 1'b1;
                            work_data.value    = {held_reg[5:0], s.value, 12'd0};
                            work_data.last_idx = 2'd0;
                        end
                    end
                    2'd2:
                    begin
                        held_next  = {held_reg[11:0], s.value};
                        phase_next = 2'd3;
                        if (last)
                        begin
                            work_push          = 1'b1;
                            work_data.value    = {held_reg[11:0], s.value, 6'd0};
                            work_data.last_idx = 2'd1;
                        end
                    end
                    default:
                    begin
                        work_push          = 1'b1;
                        work_data.value    = {held_reg[17:0], s.value};
                        work_data.last_idx = 2'd2;
                    end
                endcase
                if (work_push)
                begin
                    phase_next = 2'd0;
                    held_next  = 18'd0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b1;
            phase_reg   <= 2'd0;
            held_reg    <= 18'd0;
            discard_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            held_reg    <= held_next;
            discard_reg <= discard_next;
        end
    end

endmodule

### rtl/b64u_queue.sv
// ----------------------------------------------------------------------------
// b64u_queue
// Small job queue between the front and back halves.
// ----------------------------------------------------------------------------
`include "base64url_codec_core_assert.svh"

module b64u_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64u_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output b64u_pkg::work_t head,
    output logic            empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    b64u_pkg::work_t mem_reg [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;

    assign full  = (count_reg == FullCnt);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `B64U_ASSERT_NEVER(a_push_when_full, clk, rst_n, push && full && !pop)
    `B64U_ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && empty)
    `B64U_ASSERT(a_count_bounded, clk, rst_n, count_reg <= FullCnt)

endmodule

### rtl/b64u_back.sv
// ----------------------------------------------------------------------------
// b64u_back
// Expands queued jobs into results, one per cycle while the output register is empty or popped.
// ----------------------------------------------------------------------------
`include "base64url_codec_core_assert.svh"

module b64u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64u_pkg::work_t     q_head,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output b64u_pkg::out_item_t out_data
);

    logic [1:0]          idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    b64u_pkg::out_item_t out_data_reg;
    b64u_pkg::out_item_t result;
    logic                load;
    logic                done;
    logic [5:0]          sextet;
    logic [7:0]          dec_byte;

    assign empty    = !out_valid_reg;
    assign out_data = out_data_reg;

    assign load  = !q_empty && (!out_valid_reg || pop);
    assign done  = (idx_reg == q_head.last_idx);
    assign q_pop = load && done;

    // field select for the current result
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = q_head.value[23:18];
            2'd1:    sextet = q_head.value[17:12];
            2'd2:    sextet = q_head.value[11:6];
            default: sextet = q_head.value[5:0];
        endcase
        case (idx_reg)
            2'd0:    dec_byte = q_head.value[23:16];
            2'd1:    dec_byte = q_head.value[15:8];
            default: dec_byte = q_head.value[7:0];
        endcase
    end

    // result formatting
    always_comb
    begin
        result.out_byte       = 8'd0;
        result.has_data       = 1'b0;
        result.bad_char       = 1'b0;
        result.end_of_message = 1'b1;
        case (q_head.kind)
            b64u_pkg::KIND_ENC:
            begin
                result.out_byte       = b64u_pkg::sextet_to_char(sextet);
                result.has_data       = 1'b1;
                result.end_of_message = q_head.eom && done;
            end
            b64u_pkg::KIND_DEC:
            begin
                result.out_byte       = dec_byte;
                result.has_data       = 1'b1;
                result.end_of_message = q_head.eom && done;
            end
            b64u_pkg::KIND_BAD:
                result.bad_char = 1'b1;
            default:
                result.bad_char = 1'b0;
        endcase
    end

    // result index and output valid
    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = done ? 2'd0 : idx_reg + 2'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= result;
    end

    `B64U_ASSERT(a_idx_in_job, clk, rst_n, !q_empty |-> idx_reg <= q_head.last_idx)
    `B64U_ASSERT(a_bad_ends_msg, clk, rst_n, out_valid_reg && out_data_reg.bad_char |-> !out_data_reg.has_data && out_data_reg.end_of_message)
    `B64U_ASSERT(a_stall_holds, clk, rst_n, out_valid_reg && !pop |=> out_valid_reg && $stable(out_data_reg))

endmodule

### rtl/base64url_codec_core.sv
// A job passes through the job queue and then the output register before its first result shows.
// Throughput: one input transfer per cycle while the job queue has room; one result
// per cycle from the expander if popped: decode 1 char per cycle, encode 3 bytes per 4 results.
// The expander in b64u_back, emitting one result a cycle unless stalled, sets the sustained rate.
// Reset: rst_n clears the queue, the output valid flag and group state; encode mode is selected.
// ----------------------------------------------------------------------------
// base64url_codec_core
// Unpadded base64url encoder/decoder with queue-style ports on both sides.
// ----------------------------------------------------------------------------
module base64url_codec_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  b64u_pkg::in_item_t  in_data,
    output logic                empty,
    input  logic                pop,
    output b64u_pkg::out_item_t out_data
);

    logic            accept;
    logic            work_push;
    b64u_pkg::work_t work_data;
    b64u_pkg::work_t q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    // input transfer
    assign full   = q_full;
    assign accept = push && !q_full;

    b64u_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_data     (in_data),
        .work_push   (work_push),
        .work_data   (work_data)
    );

    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (work_push),
        .push_data (work_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    b64u_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_data (out_data)
    );

endmodule
